>>> rtl/sssp_pkg.sv
`timescale 1ns / 1ps

package sssp_pkg;

    // Event codes carried in the opcode field.
    typedef enum logic [2:0] {
        OP_ZERO_CROSS   = 3'd0,
        OP_FINE_TICK    = 3'd1,
        OP_RAMP_TICK    = 3'd2,
        OP_SAMPLE       = 3'd3,
        OP_START_RAMP   = 3'd4,
        OP_START_MANUAL = 3'd5,
        OP_STOP_RAMP    = 3'd6,
        OP_EMERGENCY    = 3'd7
    } opcode_t;

    // Status codes reported on status_code.
    localparam logic [2:0] STAT_OFF       = 3'd0;
    localparam logic [2:0] STAT_RUNNING   = 3'd1;
    localparam logic [2:0] STAT_HELD      = 3'd2;
    localparam logic [2:0] STAT_TRIP      = 3'd3;
    localparam logic [2:0] STAT_HIGH_CUR  = 3'd4;
    localparam logic [2:0] STAT_RAMP_DONE = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_ANGLE = 2'd0;
    localparam logic [1:0] CFG_END_ANGLE   = 2'd1;
    localparam logic [1:0] CFG_RAMP_RELOAD = 2'd2;

    localparam int          CFG_INDEX_W  = 2;
    localparam int          CFG_DATA_W   = 16;
    localparam logic [7:0]  RELOAD_RESET = 8'd237;

    // Bit positions inside the mode flags.
    localparam int MF_ZC_EN   = 0;
    localparam int MF_RAMP_EN = 1;
    localparam int MF_UP      = 2;
    localparam int MF_DOWN    = 3;
    localparam int MF_MANUAL  = 4;

    localparam logic [15:0] ANGLE_OFF_FLOOR   = 16'd27000;
    localparam logic [15:0] ANGLE_SAMPLE_MIN  = 16'd44500;
    localparam logic [9:0]  CUR_HOLD_LIMIT    = 10'd500;
    localparam logic [9:0]  CUR_TRIP_LIMIT    = 10'd620;
    localparam logic [9:0]  CUR_RELEASE_LIMIT = 10'd230;
    localparam logic [9:0]  CUR_MAN_HIGH      = 10'd400;
    localparam logic [9:0]  CUR_MAN_TRIP      = 10'd600;
    localparam logic [3:0]  ZC_DIVIDE         = 4'd10;

    typedef struct packed {
        logic [15:0] firing_angle;
        logic [15:0] firing_counter;
        logic        firing_armed;
        logic        gate_level;
        logic        bypass_level;
        logic        active_flag;
        logic [4:0]  mode_flags;
        logic [7:0]  ramp_prescale;
        logic [3:0]  zero_cross_divider;
        logic [2:0]  status_value;
        logic        hold_flag;
    } ctrl_state_t;

    typedef struct packed {
        logic [15:0] ramp_start_angle;
        logic [15:0] ramp_end_angle;
        logic [7:0]  ramp_reload;
    } ctrl_cfg_t;

    typedef struct packed {
        logic       gate_drive;
        logic       bypass_drive;
        logic       motor_on;
        logic [2:0] status_code;
        logic       sample_request;
    } ctrl_result_t;

endpackage

>>> rtl/sssp_in_if.sv
`timescale 1ns / 1ps

interface sssp_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [9:0] current_sample;

    modport source (output valid, output opcode, output current_sample, input ready);
    modport sink (input valid, input opcode, input current_sample, output ready);
endinterface

>>> rtl/sssp_out_if.sv
`timescale 1ns / 1ps

interface sssp_out_if;
    logic       valid;
    logic       ready;
    logic       gate_drive;
    logic       bypass_drive;
    logic       motor_on;
    logic [2:0] status_code;
    logic       sample_request;

    modport source (output valid, output gate_drive, output bypass_drive, output motor_on,
                    output status_code, output sample_request, input ready);
    modport sink (input valid, input gate_drive, input bypass_drive, input motor_on,
                  input status_code, input sample_request, output ready);
endinterface

>>> rtl/sssp_step.sv
`timescale 1ns / 1ps

// Next-state and result logic for one event.
module sssp_step (
    input  sssp_pkg::ctrl_state_t  cur,
    input  sssp_pkg::ctrl_cfg_t    cfg,
    input  logic [2:0]             opcode,
    input  logic [9:0]             current_sample,
    output sssp_pkg::ctrl_state_t  nxt,
    output sssp_pkg::ctrl_result_t res
);
    import sssp_pkg::*;

    ctrl_state_t s;
    logic        req;
    logic        up;

    // Shut-down path shared by a current trip and an emergency stop.
    function automatic ctrl_state_t trip_off(ctrl_state_t st, logic [15:0] start_angle);
        ctrl_state_t t;
        t = st;
        t.firing_armed = 1'b0;
        t.bypass_level = 1'b0;
        t.gate_level = 1'b0;
        t.active_flag = 1'b0;
        t.mode_flags[MF_RAMP_EN] = 1'b0;
        t.mode_flags[MF_MANUAL] = 1'b0;
        t.firing_angle = start_angle;
        return t;
    endfunction

    always_comb
    begin
        s = cur;
        req = 1'b0;
        up = cur.mode_flags[MF_UP];
        unique case (opcode)
            OP_ZERO_CROSS:
            begin
                if (s.mode_flags[MF_ZC_EN] && s.active_flag)
                begin
                    s.zero_cross_divider = s.zero_cross_divider + 4'd1;
                    if (s.zero_cross_divider == ZC_DIVIDE)
                    begin
                        s.zero_cross_divider = '0;
                        req = 1'b1;
                    end
                    s.firing_armed = 1'b1;
                    s.gate_level = 1'b0;
                    s.firing_counter = s.firing_angle;
                end
            end
            OP_FINE_TICK:
            begin
                if (s.firing_armed)
                begin
                    s.firing_counter = s.firing_counter + 16'd1;
                    if (s.firing_counter == '0)
                    begin
                        s.gate_level = 1'b1;
                        s.firing_armed = 1'b0;
                        s.firing_counter = s.firing_angle;
                    end
                end
            end
            OP_RAMP_TICK:
            begin
                if (s.ramp_prescale == 8'hFF)
                begin
                    if (s.mode_flags[MF_RAMP_EN])
                    begin
                        s.ramp_prescale = cfg.ramp_reload;
                        // Upward step first, then the downward step if that is set too.
                        if (s.mode_flags[MF_UP])
                        begin
                            s.firing_angle = s.firing_angle + 16'd1;
                            if (s.firing_angle >= cfg.ramp_end_angle)
                            begin
                                s.mode_flags[MF_RAMP_EN] = 1'b0;
                                s.mode_flags[MF_UP] = 1'b0;
                                s.bypass_level = 1'b1;
                                s.status_value = STAT_RAMP_DONE;
                            end
                        end
                        if (s.mode_flags[MF_DOWN])
                        begin
                            s.firing_angle = s.firing_angle - 16'd1;
                            if (s.firing_angle <= ANGLE_OFF_FLOOR)
                            begin
                                s.mode_flags[MF_RAMP_EN] = 1'b0;
                                s.mode_flags[MF_ZC_EN] = 1'b0;
                                s.mode_flags[MF_DOWN] = 1'b0;
                                s.firing_armed = 1'b0;
                                s.active_flag = 1'b0;
                                s.gate_level = 1'b0;
                                s.firing_counter = '0;
                                s.status_value = STAT_OFF;
                            end
                        end
                    end
                    else
                    begin
                        s.ramp_prescale = '0;
                    end
                end
                else
                begin
                    s.ramp_prescale = s.ramp_prescale + 8'd1;
                end
            end
            OP_SAMPLE:
            begin
                if (s.firing_angle > ANGLE_SAMPLE_MIN && s.active_flag)
                begin
                    if (current_sample > CUR_HOLD_LIMIT && up && !s.hold_flag
                        && !s.mode_flags[MF_MANUAL])
                    begin
                        s.mode_flags[MF_RAMP_EN] = 1'b0;
                        s.hold_flag = 1'b1;
                        s.status_value = STAT_HELD;
                    end
                    if (current_sample > CUR_HOLD_LIMIT && !up)
                    begin
                        s.status_value = STAT_HIGH_CUR;
                    end
                    if (current_sample > CUR_TRIP_LIMIT)
                    begin
                        s = trip_off(s, cfg.ramp_start_angle);
                        s.status_value = STAT_TRIP;
                    end
                    if (current_sample < CUR_RELEASE_LIMIT && s.hold_flag)
                    begin
                        s.mode_flags[MF_RAMP_EN] = 1'b1;
                        s.hold_flag = 1'b0;
                        s.status_value = STAT_RUNNING;
                    end
                end
                if (s.mode_flags[MF_MANUAL])
                begin
                    if (current_sample > CUR_MAN_HIGH)
                    begin
                        s.status_value = STAT_HIGH_CUR;
                    end
                    if (current_sample > CUR_MAN_TRIP)
                    begin
                        s = trip_off(s, cfg.ramp_start_angle);
                        s.status_value = STAT_TRIP;
                    end
                end
            end
            OP_START_RAMP:
            begin
                s.firing_angle = cfg.ramp_start_angle;
                s.firing_armed = 1'b0;
                s.mode_flags[MF_ZC_EN] = 1'b1;
                s.mode_flags[MF_RAMP_EN] = 1'b1;
                s.mode_flags[MF_UP] = 1'b1;
                s.ramp_prescale = cfg.ramp_reload;
                s.firing_counter = cfg.ramp_start_angle;
                s.active_flag = 1'b1;
                s.status_value = STAT_RUNNING;
            end
            OP_START_MANUAL:
            begin
                s.firing_angle = cfg.ramp_start_angle;
                s.mode_flags[MF_ZC_EN] = 1'b1;
                s.mode_flags[MF_MANUAL] = 1'b1;
                s.firing_counter = cfg.ramp_start_angle;
                s.active_flag = 1'b1;
                s.status_value = STAT_RUNNING;
            end
            OP_STOP_RAMP:
            begin
                s.mode_flags[MF_RAMP_EN] = 1'b1;
                s.mode_flags[MF_DOWN] = 1'b1;
                s.mode_flags[MF_UP] = 1'b0;
                s.ramp_prescale = cfg.ramp_reload;
                s.active_flag = 1'b1;
            end
            default:
            begin
                s = trip_off(s, cfg.ramp_start_angle);
            end
        endcase

        // Drives are forced low whenever the controller is not active.
        if (!s.active_flag)
        begin
            s.gate_level = 1'b0;
            s.bypass_level = 1'b0;
        end

        nxt = s;
        res.gate_drive = s.gate_level;
        res.bypass_drive = s.bypass_level;
        res.motor_on = s.active_flag;
        res.status_code = s.status_value;
        res.sample_request = req;
    end

endmodule

>>> rtl/soft_start_phase_angle_controller_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// item      in         opcode (3), current_sample (10)
// result    out        gate_drive, bypass_drive, motor_on, status_code (3), sample_request
// wr_*      in         wr_en, wr_index (2), wr_data (16); no handshake, no read-back
//
// Every event beat yields exactly one result beat, via the input and then the output register.
// A new beat can be taken every cycle while the result is not stalled: an input register feeds
// the combinational event logic, whose result lands in the output register with the state update.
// The input register frees itself whenever the output register is empty or being drained,
// so a stalled result only blocks the input once both registers are full.
// rst_n clears all control state; zero-cross enable is the only mode flag set after reset.
module soft_start_phase_angle_controller_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    sssp_in_if.sink                            item,
    sssp_out_if.source                         result,
    input  logic                               wr_en,
    input  logic [sssp_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [sssp_pkg::CFG_DATA_W-1:0]    wr_data
);
    import sssp_pkg::*;

    // Controller state right after reset: only zero-cross detection is enabled.
    localparam ctrl_state_t STATE_RESET = '{
        firing_angle:       '0,
        firing_counter:     '0,
        firing_armed:       1'b0,
        gate_level:         1'b0,
        bypass_level:       1'b0,
        active_flag:        1'b0,
        mode_flags:         5'(1 << MF_ZC_EN),
        ramp_prescale:      '0,
        zero_cross_divider: '0,
        status_value:       STAT_OFF,
        hold_flag:          1'b0
    };

    // Input stage.
    logic        in_valid_reg;
    logic [2:0]  opcode_reg;
    logic [9:0]  sample_reg;

    // Configuration registers.
    ctrl_cfg_t   cfg_reg;

    // Controller state and its next value from the event logic.
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    ctrl_state_t step_state;

    // Output stage.
    logic         out_valid_reg;
    ctrl_result_t result_reg;
    ctrl_result_t step_result;

    logic advance;

    // The event in the input stage is processed when the output register can take its result.
    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    sssp_step u_step (
        .cur            (state_reg),
        .cfg            (cfg_reg),
        .opcode         (opcode_reg),
        .current_sample (sample_reg),
        .nxt            (step_state),
        .res            (step_result)
    );

    // Writing the start angle also loads the firing angle right away. Writes must only
    // arrive while the block is idle; the block itself does not enforce this.
    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            state_next = step_state;
        end
        if (wr_en && wr_index == CFG_START_ANGLE)
        begin
            state_next.firing_angle = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg <= '{ramp_start_angle: '0, ramp_end_angle: '0, ramp_reload: RELOAD_RESET};
            state_reg <= STATE_RESET;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                unique case (wr_index)
                    CFG_START_ANGLE: cfg_reg.ramp_start_angle <= wr_data;
                    CFG_END_ANGLE:   cfg_reg.ramp_end_angle <= wr_data;
                    CFG_RAMP_RELOAD: cfg_reg.ramp_reload <= wr_data[7:0];
                    default:         ;
                endcase
            end
            state_reg <= state_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            opcode_reg <= item.opcode;
            sample_reg <= item.current_sample;
        end
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.gate_drive = result_reg.gate_drive;
    assign result.bypass_drive = result_reg.bypass_drive;
    assign result.motor_on = result_reg.motor_on;
    assign result.status_code = result_reg.status_code;
    assign result.sample_request = result_reg.sample_request;

    // A reported drive or sample request implies the controller was active.
    a_drives_need_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.motor_on |->
            !result_reg.gate_drive && !result_reg.bypass_drive && !result_reg.sample_request)
        else $error("drive or sample request reported while motor is off");

    // An event held in the input stage keeps its contents until it is processed.
    a_input_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=>
            in_valid_reg && $stable(opcode_reg) && $stable(sample_reg))
        else $error("input stage changed before its event was processed");

    // A processed event always leaves a result in the output register.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed event left no result");

    // An inactive controller never holds its gate or bypass high.
    a_state_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.active_flag |-> !state_reg.gate_level && !state_reg.bypass_level)
        else $error("gate or bypass level set while inactive");

endmodule
